// ----- sv/krt_pkg.sv -----
package krt_pkg;

  // Default table capacity.
  localparam int MAX_ROUTES_DEF = 64;

  localparam int KEY_W = 64;
  localparam int PAY_W = 41;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_ADD         = 2'd0;
  localparam logic [1:0] OP_REMOVE_AT   = 2'd1;
  localparam logic [1:0] OP_REMOVE_DEST = 2'd2;
  localparam logic [1:0] OP_FIND        = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // One table entry: key is {source_id, destination_id}, payload is
  // {curve_code, bipolar_flag, depth_bits}.
  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

// ----- sv/krt_mem.sv -----
module krt_mem #(
  parameter int DEPTH = krt_pkg::MAX_ROUTES_DEF,
  parameter int AW    = $clog2(krt_pkg::MAX_ROUTES_DEF)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  krt_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output krt_pkg::entry_t rd_data
);

  // Single write port, single registered read port.
  krt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/keyed_route_table_top.sv -----
// Keyed route table. Holds an ordered list of up to MAX_ROUTES routes, each
// keyed by a source and destination pair and carrying a depth word, a
// bipolar flag and a curve code. An item on the input stream selects one of
// four operations through in_tuser: add (update in place if the key exists,
// append otherwise, refuse with a full status at capacity), remove at index
// (delete one entry and close the gap, out-of-range indexes are flagged and
// ignored), remove by destination (delete every match and compact, keeping
// order) and find (report a hit and the first matching index). Each item
// produces exactly one result item. The table lives in a memory with one
// write port and one registered read port, and one sequencer walks it
// entry by entry, each through a read state and a compare-and-move state.
// The entries visited are those up to the first hit for add and find,
// those behind the index for remove at index and all valid entries for
// remove by destination. The block accepts one item at a time; the result
// sits in an output register so the next item may be taken while that
// result still waits. The table contents need no clearing after reset:
// only entries below the valid count are ever read.
module keyed_route_table_top #(
  parameter int MAX_ROUTES = krt_pkg::MAX_ROUTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: source_id[31:0], destination_id[63:32],
  // depth_bits[95:64], bipolar_flag[96], curve_code[104:97],
  // entry_index[110:105], zero fill[111].
  input  logic [111:0] in_tdata,
  // Fields: operation[1:0].
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0 up: status[1:0], hit[2], result_index[8:3],
  // entry_count[15:9], removed_count[22:16], zero fill[23].
  output logic [23:0]  out_tdata
);

  // Address width and count width (the count must also hold MAX_ROUTES).
  localparam int AW   = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CW   = $clog2(MAX_ROUTES + 1);
  // Widths used to compare the 6-bit index and to report fixed-width fields.
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int OCW  = (CW > 7) ? CW : 7;
  localparam int OPW  = (AW > 6) ? AW : 6;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CK   = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [23:0]                 out_data_r, out_data_nxt;

  // Per-item working registers.
  logic [1:0]                  op_r, op_nxt;
  logic [krt_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [krt_pkg::PAY_W-1:0]   pay_r, pay_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        hit_r, hit_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [CW-1:0]               w_r, w_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  krt_pkg::entry_t             mem_wdata;
  logic [AW-1:0]               mem_raddr;
  krt_pkg::entry_t             mem_rdata;

  logic [CMPW-1:0]             idx_ext;
  logic [CMPW-1:0]             cnt_cmp;
  logic [CW-1:0]               first_i;
  logic [CW-1:0]               i_inc;
  logic                        match_key;
  logic                        match_dst;
  logic [OCW-1:0]              cnt_out;
  logic [OCW-1:0]              rem_out;
  logic [OPW-1:0]              pos_out;

  krt_mem #(
    .DEPTH (MAX_ROUTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign idx_ext   = CMPW'(in_tdata[110:105]);
  assign cnt_cmp   = CMPW'(cnt_r);
  assign first_i   = CW'(idx_ext) + CW'(1);
  assign i_inc     = i_r + CW'(1);
  assign match_key = (mem_rdata.key == key_r);
  assign match_dst = (mem_rdata.key[31:0] == key_r[31:0]);
  assign cnt_out   = OCW'(cnt_r);
  assign rem_out   = OCW'(rem_r);
  assign pos_out   = OPW'(pos_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    rem_nxt       = rem_r;
    mem_we        = 1'b0;
    mem_waddr     = w_r[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = i_r[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          key_nxt    = {in_tdata[31:0], in_tdata[63:32]};
          pay_nxt    = {in_tdata[104:97], in_tdata[96], in_tdata[95:64]};
          status_nxt = krt_pkg::ST_OK;
          hit_nxt    = 1'b0;
          pos_nxt    = '0;
          rem_nxt    = '0;
          w_nxt      = '0;
          i_nxt      = '0;
          if (in_tuser == krt_pkg::OP_REMOVE_AT) begin
            if (idx_ext >= cnt_cmp) begin
              status_nxt = krt_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              // Start at the entry just behind the one being deleted.
              i_nxt     = first_i;
              state_nxt = (first_i < cnt_r) ? S_RD : S_END;
            end
          end else begin
            state_nxt = (cnt_r != '0) ? S_RD : S_END;
          end
        end
      end

      S_RD: begin
        state_nxt = S_CK;
      end

      S_CK: begin
        i_nxt     = i_inc;
        state_nxt = (i_inc < cnt_r) ? S_RD : S_END;
        case (op_r)
          krt_pkg::OP_REMOVE_AT: begin
            // Shift each later entry down by one place.
            mem_we    = 1'b1;
            mem_waddr = AW'(i_r - CW'(1));
          end
          krt_pkg::OP_REMOVE_DEST: begin
            if (match_dst) begin
              rem_nxt = rem_r + CW'(1);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = w_r[AW-1:0];
              w_nxt     = w_r + CW'(1);
            end
          end
          default: begin
            // Add and find stop at the first matching key.
            if (match_key) begin
              hit_nxt   = 1'b1;
              pos_nxt   = i_r[AW-1:0];
              state_nxt = S_END;
            end
          end
        endcase
      end

      S_END: begin
        state_nxt = S_DONE;
        case (op_r)
          krt_pkg::OP_ADD: begin
            mem_wdata.key     = key_r;
            mem_wdata.payload = pay_r;
            if (hit_r) begin
              mem_we    = 1'b1;
              mem_waddr = pos_r;
            end else if (cnt_r == CW'(MAX_ROUTES)) begin
              status_nxt = krt_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_r[AW-1:0];
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
            end
          end
          krt_pkg::OP_REMOVE_AT: begin
            cnt_nxt = cnt_r - CW'(1);
            rem_nxt = CW'(1);
          end
          krt_pkg::OP_REMOVE_DEST: begin
            cnt_nxt = w_r;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, rem_out[6:0], cnt_out[6:0], pos_out[5:0],
                           hit_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    w_r        <= w_nxt;
    rem_r      <= rem_nxt;
  end

  // The valid count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ROUTES))
    else $error("route count exceeds capacity");

  // The table is only written in the compare step or the closing step.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CK || state_r == S_END))
    else $error("table write outside the compare or closing step");

  // A remove at index that reaches its closing step drops exactly one entry.
  a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && op_r == krt_pkg::OP_REMOVE_AT)
    |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("remove at index did not drop exactly one entry");

  // A full status is only reported with the table at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == krt_pkg::ST_FULL)
    |-> (cnt_r == CW'(MAX_ROUTES)))
    else $error("full status with room left in the table");

endmodule
